[src/ahtc_pkg.sv]
`default_nettype none
package ahtc_pkg;

    localparam int NODES    = 1024;
    localparam int IDX_W    = $clog2(NODES);
    localparam int W_W      = 32;
    localparam int MAX_BITS = 512;
    localparam int LEN_W    = $clog2(MAX_BITS) + 1;
    localparam int CHUNK_W  = 64;
    localparam int K_W      = $clog2(MAX_BITS / CHUNK_W);
    localparam logic [W_W-1:0] WEIGHT_LIMIT = '1;

    // One node table entry
    typedef struct packed {
        logic [7:0]       sym;
        logic [W_W-1:0]   weight;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [IDX_W-1:0] parent;
        logic             leaf;
    } t_node;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ROOT, S_ROOT_D, S_SRCH,
        S_W_RD, S_W_PAR, S_W_LVL, S_W_BIT, S_OUT,
        S_A_RD, S_A_E, S_A_L, S_A_R,
        S_U_RD, S_U_INC, S_U_SCAN, S_U_NEXT,
        S_F_RD, S_F_WR, S_S_RA, S_S_RB, S_S_WA, S_S_WB
    } t_state;

    // Map an index beyond the table to the anchor entry
    function automatic logic [IDX_W-1:0] ix(input logic [IDX_W-1:0] v);
        return ({1'b0, v} < (IDX_W+1)'(NODES)) ? v : '0;
    endfunction

    // Entry contents after reset
    function automatic t_node node_init(input logic [IDX_W-1:0] a);
        t_node n;
        n = '0;
        if (a == IDX_W'(1)) begin
            n.weight = W_W'(2);
            n.left   = IDX_W'(2);
            n.right  = IDX_W'(3);
        end else if (a == IDX_W'(2) || a == IDX_W'(3)) begin
            n.weight = W_W'(1);
            n.parent = IDX_W'(1);
            n.leaf   = 1'b1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[src/ahtc_chunk_out.sv]
`default_nettype none
module ahtc_chunk_out (
    input  wire logic [ahtc_pkg::MAX_BITS-1:0] i_code,
    input  wire logic [ahtc_pkg::LEN_W-1:0]    i_len,
    input  wire logic [ahtc_pkg::K_W-1:0]      i_k,
    output logic [ahtc_pkg::CHUNK_W-1:0]       o_chunk,
    output logic [6:0]                         o_bits,
    output logic                               o_last
);
    logic [ahtc_pkg::LEN_W-1:0] w_base;
    logic [ahtc_pkg::LEN_W-1:0] w_rem;
    logic [ahtc_pkg::LEN_W-1:0] w_up;
    logic [ahtc_pkg::K_W-1:0]   w_klast;

    // Select the chunk and count its valid bits
    always_comb begin
        w_base  = ahtc_pkg::LEN_W'({i_k, 6'd0});
        w_rem   = (i_len >= w_base) ? (i_len - w_base) : '0;
        o_bits  = (w_rem > ahtc_pkg::LEN_W'(64)) ? 7'd64 : w_rem[6:0];
        o_chunk = i_code[{i_k, 6'd0} +: ahtc_pkg::CHUNK_W];
        w_up    = i_len + ahtc_pkg::LEN_W'(63);
        w_klast = (i_len == '0) ? '0 : ahtc_pkg::K_W'((w_up >> 6) - ahtc_pkg::LEN_W'(1));
        o_last  = (i_k == w_klast);
    end
endmodule
`default_nettype wire

[src/adaptive_huffman_tree_coder_top.sv]
`default_nettype none
// Adaptive Huffman coder with the tree held in a 1024-entry node memory
// (one read or write per cycle, registered read data). After reset a
// clearing pass writes the initial tree to every entry before the first word
// is taken. One item is handled at a time: a leaf search reads up to 1023
// entries (about one per cycle), the code walk reads one entry per tree
// level, and each level of the weight update reads and increments the
// current node, scans the entries below it and may swap it with one of them.
module adaptive_huffman_tree_coder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_end_request,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_code_chunk,
    output logic [6:0]       o_chunk_bits,
    output logic             o_is_new,
    output logic             o_weight_saturated,
    output logic             o_last
);
    localparam int IW = ahtc_pkg::IDX_W;

    ahtc_pkg::t_node  r_mem [ahtc_pkg::NODES];
    ahtc_pkg::t_node  r_rdata;
    logic [IW-1:0]    w_addr;
    logic             w_we;
    ahtc_pkg::t_node  w_wdata;

    ahtc_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_clr, n_clr;
    logic [7:0]       r_sym, n_sym;
    logic             r_end, n_end, r_sat, n_sat, r_new, n_new;
    logic [IW-1:0]    r_esc, n_esc, r_endi, n_endi;
    logic [IW-1:0]    r_leaf, n_leaf, r_pos, n_pos, r_par, n_par;
    logic [ahtc_pkg::LEN_W-1:0]    r_len, n_len;
    logic [ahtc_pkg::MAX_BITS-1:0] r_code, n_code;
    logic [ahtc_pkg::K_W-1:0]      r_k, n_k;
    logic [IW-1:0]    r_cur, n_cur, r_pb, n_pb, r_chk, n_chk;
    logic [IW:0]      r_steps, n_steps, r_idx, n_idx;
    logic             r_chkv, n_chkv;
    ahtc_pkg::t_node  r_a, n_a, r_b, n_b;
    logic [1:0]       r_fx, n_fx;

    logic             w_last;
    logic [IW-1:0]    w_tgt, w_tval;
    logic             w_tcond;

    // Node memory, read-first single port
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    // Format the current output word
    ahtc_chunk_out u_chunk (
        .i_code  (r_code),
        .i_len   (r_len),
        .i_k     (r_k),
        .o_chunk (o_code_chunk),
        .o_bits  (o_chunk_bits),
        .o_last  (w_last)
    );

    assign o_ready            = (r_state == ahtc_pkg::S_IDLE);
    assign o_valid            = (r_state == ahtc_pkg::S_OUT);
    assign o_is_new           = r_new;
    assign o_weight_saturated = r_sat;
    assign o_last             = w_last;

    // Select the child whose parent link is fixed in a swap
    always_comb begin
        unique case (r_fx)
            2'd0: begin w_tgt = ahtc_pkg::ix(r_a.left);  w_tval = r_pb;  end
            2'd1: begin w_tgt = ahtc_pkg::ix(r_a.right); w_tval = r_pb;  end
            2'd2: begin w_tgt = ahtc_pkg::ix(r_b.left);  w_tval = r_cur; end
            default: begin w_tgt = ahtc_pkg::ix(r_b.right); w_tval = r_cur; end
        endcase
        w_tcond = r_fx[1] ? (r_b.left != '0) : (r_a.left != '0);
    end

    // Sequencer: next state and memory port
    always_comb begin
        n_state = r_state; n_clr = r_clr; n_sym = r_sym; n_end = r_end;
        n_sat = r_sat; n_new = r_new; n_esc = r_esc; n_endi = r_endi;
        n_leaf = r_leaf; n_pos = r_pos; n_par = r_par; n_len = r_len;
        n_code = r_code; n_k = r_k; n_cur = r_cur; n_pb = r_pb;
        n_chk = r_chk; n_steps = r_steps; n_idx = r_idx; n_chkv = r_chkv;
        n_a = r_a; n_b = r_b; n_fx = r_fx;
        w_addr = r_idx[IW-1:0]; w_we = 1'b0; w_wdata = r_rdata;
        unique case (r_state)
            ahtc_pkg::S_CLEAR: begin
                w_addr  = r_clr;
                w_we    = 1'b1;
                w_wdata = ahtc_pkg::node_init(r_clr);
                n_clr   = r_clr + IW'(1);
                if (r_clr == IW'(ahtc_pkg::NODES - 1)) n_state = ahtc_pkg::S_IDLE;
            end
            ahtc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_sym  = i_symbol;
                    n_end  = i_end_request;
                    n_sat  = 1'b0;
                    n_new  = 1'b0;
                    n_len  = '0;
                    n_code = '0;
                    if (i_end_request) begin
                        n_leaf  = r_endi;
                        n_pos   = r_endi;
                        n_state = ahtc_pkg::S_W_RD;
                    end else begin
                        n_state = ahtc_pkg::S_ROOT;
                    end
                end
            end
            ahtc_pkg::S_ROOT: begin
                w_addr  = IW'(1);
                n_state = ahtc_pkg::S_ROOT_D;
            end
            ahtc_pkg::S_ROOT_D: begin
                n_sat   = (r_rdata.weight == ahtc_pkg::WEIGHT_LIMIT);
                n_idx   = (IW+1)'(1);
                n_chkv  = 1'b0;
                n_state = ahtc_pkg::S_SRCH;
            end
            // Scan the table for the symbol's leaf, one entry per cycle
            ahtc_pkg::S_SRCH: begin
                if (r_chkv && r_rdata.sym == r_sym && r_rdata.leaf
                        && r_chk != r_endi && r_chk != r_esc) begin
                    n_leaf  = r_chk;
                    n_pos   = r_chk;
                    n_state = ahtc_pkg::S_W_RD;
                end else if (r_chkv && r_chk == IW'(ahtc_pkg::NODES - 1)) begin
                    n_new   = 1'b1;
                    n_leaf  = r_esc;
                    n_pos   = r_esc;
                    n_state = ahtc_pkg::S_W_RD;
                end else begin
                    n_chk  = r_idx[IW-1:0];
                    n_chkv = 1'b1;
                    n_idx  = r_idx + (IW+1)'(1);
                end
            end
            // Walk from the leaf to the root collecting code bits
            ahtc_pkg::S_W_RD: begin
                w_addr  = r_pos;
                n_state = ahtc_pkg::S_W_PAR;
            end
            ahtc_pkg::S_W_PAR: begin
                n_par   = ahtc_pkg::ix(r_rdata.parent);
                n_state = ahtc_pkg::S_W_LVL;
            end
            ahtc_pkg::S_W_LVL: begin
                if (r_pos > IW'(1) && r_len < ahtc_pkg::LEN_W'(ahtc_pkg::MAX_BITS)) begin
                    w_addr  = r_par;
                    n_state = ahtc_pkg::S_W_BIT;
                end else begin
                    n_k     = '0;
                    n_state = ahtc_pkg::S_OUT;
                end
            end
            ahtc_pkg::S_W_BIT: begin
                if (r_pos == r_rdata.right)
                    n_code[r_len[ahtc_pkg::LEN_W-2:0]] = 1'b1;
                n_pos   = r_par;
                n_par   = ahtc_pkg::ix(r_rdata.parent);
                n_len   = r_len + ahtc_pkg::LEN_W'(1);
                n_state = ahtc_pkg::S_W_LVL;
            end
            ahtc_pkg::S_OUT: begin
                if (i_ready) begin
                    if (!w_last) begin
                        n_k = r_k + ahtc_pkg::K_W'(1);
                    end else if (r_end) begin
                        n_state = ahtc_pkg::S_IDLE;
                    end else if (r_new) begin
                        if (({1'b0, r_esc} + (IW+1)'(2)) >= (IW+1)'(ahtc_pkg::NODES))
                            n_state = ahtc_pkg::S_IDLE;
                        else
                            n_state = ahtc_pkg::S_A_RD;
                    end else if (r_sat) begin
                        n_state = ahtc_pkg::S_IDLE;
                    end else begin
                        n_cur   = r_leaf;
                        n_steps = '0;
                        n_state = ahtc_pkg::S_U_RD;
                    end
                end
            end
            // Split the escape leaf
            ahtc_pkg::S_A_RD: begin
                w_addr  = r_esc;
                n_state = ahtc_pkg::S_A_E;
            end
            ahtc_pkg::S_A_E: begin
                w_addr  = r_esc;
                w_we    = 1'b1;
                w_wdata = '{sym: 8'd0, weight: ahtc_pkg::W_W'(1), left: r_esc + IW'(1),
                            right: r_esc + IW'(2), parent: r_rdata.parent, leaf: 1'b0};
                n_state = ahtc_pkg::S_A_L;
            end
            ahtc_pkg::S_A_L: begin
                w_addr  = r_esc + IW'(1);
                w_we    = 1'b1;
                w_wdata = '{sym: r_sym, weight: '0, left: '0, right: '0,
                            parent: r_esc, leaf: 1'b1};
                n_state = ahtc_pkg::S_A_R;
            end
            ahtc_pkg::S_A_R: begin
                w_addr  = r_esc + IW'(2);
                w_we    = 1'b1;
                w_wdata = '{sym: 8'd0, weight: ahtc_pkg::W_W'(1), left: '0, right: '0,
                            parent: r_esc, leaf: 1'b1};
                n_esc   = r_esc + IW'(2);
                n_cur   = r_esc + IW'(1);
                n_steps = '0;
                n_state = r_sat ? ahtc_pkg::S_IDLE : ahtc_pkg::S_U_RD;
            end
            // Weight update, one tree level per pass
            ahtc_pkg::S_U_RD: begin
                if (r_cur != '0 && r_steps < (IW+1)'(ahtc_pkg::NODES)) begin
                    w_addr  = r_cur;
                    n_state = ahtc_pkg::S_U_INC;
                end else begin
                    n_state = ahtc_pkg::S_IDLE;
                end
            end
            ahtc_pkg::S_U_INC: begin
                n_a        = r_rdata;
                n_a.weight = r_rdata.weight + ahtc_pkg::W_W'(1);
                w_addr     = r_cur;
                w_we       = 1'b1;
                w_wdata    = n_a;
                n_idx      = (IW+1)'(2);
                n_chkv     = 1'b0;
                n_state    = (r_cur <= IW'(2)) ? ahtc_pkg::S_U_NEXT : ahtc_pkg::S_U_SCAN;
            end
            ahtc_pkg::S_U_SCAN: begin
                if (r_chkv && r_rdata.weight < r_a.weight) begin
                    n_b  = r_rdata;
                    n_pb = r_chk;
                    if (r_cur == r_esc) n_esc = r_chk;
                    else if (r_chk == r_esc) n_esc = r_cur;
                    if (r_cur == r_endi) n_endi = r_chk;
                    else if (r_chk == r_endi) n_endi = r_cur;
                    n_fx    = 2'd0;
                    n_state = ahtc_pkg::S_F_RD;
                end else if (r_chkv && r_chk == r_cur - IW'(1)) begin
                    n_state = ahtc_pkg::S_U_NEXT;
                end else begin
                    n_chk  = r_idx[IW-1:0];
                    n_chkv = 1'b1;
                    n_idx  = r_idx + (IW+1)'(1);
                end
            end
            ahtc_pkg::S_U_NEXT: begin
                n_cur   = ahtc_pkg::ix(r_a.parent);
                n_steps = r_steps + (IW+1)'(1);
                n_state = ahtc_pkg::S_U_RD;
            end
            // Relink children of both swapped nodes
            ahtc_pkg::S_F_RD: begin
                if (w_tcond) begin
                    w_addr  = w_tgt;
                    n_state = ahtc_pkg::S_F_WR;
                end else if (r_fx == 2'd3) begin
                    n_state = ahtc_pkg::S_S_RA;
                end else begin
                    n_fx = r_fx + 2'd1;
                end
            end
            ahtc_pkg::S_F_WR: begin
                w_addr         = w_tgt;
                w_we           = 1'b1;
                w_wdata        = r_rdata;
                w_wdata.parent = w_tval;
                n_fx           = r_fx + 2'd1;
                n_state        = (r_fx == 2'd3) ? ahtc_pkg::S_S_RA : ahtc_pkg::S_F_RD;
            end
            // Exchange contents, parents stay with the positions
            ahtc_pkg::S_S_RA: begin
                w_addr  = r_cur;
                n_state = ahtc_pkg::S_S_RB;
            end
            ahtc_pkg::S_S_RB: begin
                n_a     = r_rdata;
                w_addr  = r_pb;
                n_state = ahtc_pkg::S_S_WA;
            end
            ahtc_pkg::S_S_WA: begin
                n_b            = r_rdata;
                w_addr         = r_cur;
                w_we           = 1'b1;
                w_wdata        = r_rdata;
                w_wdata.parent = r_a.parent;
                n_state        = ahtc_pkg::S_S_WB;
            end
            ahtc_pkg::S_S_WB: begin
                w_addr         = r_pb;
                w_we           = 1'b1;
                w_wdata        = r_a;
                w_wdata.parent = r_b.parent;
                n_cur          = ahtc_pkg::ix(r_b.parent);
                n_steps        = r_steps + (IW+1)'(1);
                n_state        = ahtc_pkg::S_U_RD;
            end
            default: n_state = ahtc_pkg::S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ahtc_pkg::S_CLEAR;
            r_clr   <= '0;
            r_esc   <= IW'(3);
            r_endi  <= IW'(2);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_esc   <= n_esc;
            r_endi  <= n_endi;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_sym <= n_sym; r_end <= n_end; r_sat <= n_sat; r_new <= n_new;
        r_leaf <= n_leaf; r_pos <= n_pos; r_par <= n_par; r_len <= n_len;
        r_code <= n_code; r_k <= n_k; r_cur <= n_cur; r_pb <= n_pb;
        r_chk <= n_chk; r_steps <= n_steps; r_idx <= n_idx; r_chkv <= n_chkv;
        r_a <= n_a; r_b <= n_b; r_fx <= n_fx;
    end
endmodule
`default_nettype wire

[src/ahtc_checker.sv]
`default_nettype none
module ahtc_sva_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [63:0] o_code_chunk,
    input wire logic [6:0]  o_chunk_bits,
    input wire logic        o_last
);
    // Never take a word while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input ready during output");

    // A word never carries more than 64 bits
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_chunk_bits <= 7'd64) else $error("chunk_bits above 64");

    // Bits beyond chunk_bits are zero
    a_clean_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code_chunk >> o_chunk_bits) == 64'd0)
        else $error("stray code bits");

    // Every word but the final one is full
    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_chunk_bits == 7'd64) else $error("short inner chunk");

    // Output holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_code_chunk)))
        else $error("output dropped while stalled");
endmodule

bind adaptive_huffman_tree_coder_top ahtc_sva_checker u_ahtc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_code_chunk (o_code_chunk),
    .o_chunk_bits (o_chunk_bits),
    .o_last       (o_last)
);
`default_nettype wire

[sim/ahtc_checker.sv]
`timescale 1ns / 1ps
module ahtc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_end_request,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_code_chunk,
    input  wire logic [6:0]  i_chunk_bits,
    input  wire logic        i_is_new,
    input  wire logic        i_weight_saturated,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct {
        logic [63:0] chunk;
        logic [6:0]  nbits;
        logic        is_new;
        logic        sat;
        logic        last;
    } t_chunk;

    // Shadow copy of the node table
    logic [7:0]                sym_tab [ahtc_pkg::NODES];
    logic [ahtc_pkg::W_W-1:0]   wt_tab  [ahtc_pkg::NODES];
    logic [ahtc_pkg::IDX_W-1:0] lft_tab [ahtc_pkg::NODES];
    logic [ahtc_pkg::IDX_W-1:0] rgt_tab [ahtc_pkg::NODES];
    logic [ahtc_pkg::IDX_W-1:0] par_tab [ahtc_pkg::NODES];
    logic                      leaf_tab[ahtc_pkg::NODES];
    int               esc_idx;
    int               end_idx;
    int               used_cnt;

    t_chunk chunk_queue[$];
    int     fail_count;
    int     pending_cnt;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    function automatic int clip(input int v);
        return (v >= 0 && v < ahtc_pkg::NODES) ? v : 0;
    endfunction

    function automatic void put_node(input int n, input logic [7:0] s,
                                     input logic [ahtc_pkg::W_W-1:0] w,
                                     input int l, input int r, input int p, input logic lf);
        n = clip(n);
        sym_tab[n]  = s;
        wt_tab[n]   = w;
        lft_tab[n]  = ahtc_pkg::IDX_W'(l);
        rgt_tab[n]  = ahtc_pkg::IDX_W'(r);
        par_tab[n]  = ahtc_pkg::IDX_W'(p);
        leaf_tab[n] = lf;
    endfunction

    function automatic void reset_tree();
        for (int i = 0; i < ahtc_pkg::NODES; i++) put_node(i, 0, 0, 0, 0, 0, 0);
        put_node(1, 0, 2, 2, 3, 0, 0);
        put_node(2, 0, 1, 0, 0, 1, 1);
        put_node(3, 0, 1, 0, 0, 1, 1);
        esc_idx  = 3;
        end_idx  = 2;
        used_cnt = 3;
    endfunction

    function automatic int find_leaf(input logic [7:0] c);
        for (int i = 1; i < ahtc_pkg::NODES; i++)
            if (sym_tab[i] == c && leaf_tab[i] && i != end_idx && i != esc_idx) return i;
        return 0;
    endfunction

    // Exchange two entries; parents stay with the positions
    function automatic void swap_entries(input int a, input int b);
        logic [7:0]                ts;
        logic [ahtc_pkg::W_W-1:0]   tw;
        logic [ahtc_pkg::IDX_W-1:0] tl, tr;
        logic                      tf;
        if (a == esc_idx) esc_idx = b;
        else if (b == esc_idx) esc_idx = a;
        if (a == end_idx) end_idx = b;
        else if (b == end_idx) end_idx = a;
        if (lft_tab[a] != 0) begin
            par_tab[clip(lft_tab[a])] = ahtc_pkg::IDX_W'(b);
            par_tab[clip(rgt_tab[a])] = ahtc_pkg::IDX_W'(b);
        end
        if (lft_tab[b] != 0) begin
            par_tab[clip(lft_tab[b])] = ahtc_pkg::IDX_W'(a);
            par_tab[clip(rgt_tab[b])] = ahtc_pkg::IDX_W'(a);
        end
        ts = sym_tab[a];  sym_tab[a]  = sym_tab[b];  sym_tab[b]  = ts;
        tw = wt_tab[a];   wt_tab[a]   = wt_tab[b];   wt_tab[b]   = tw;
        tl = lft_tab[a];  lft_tab[a]  = lft_tab[b];  lft_tab[b]  = tl;
        tr = rgt_tab[a];  rgt_tab[a]  = rgt_tab[b];  rgt_tab[b]  = tr;
        tf = leaf_tab[a]; leaf_tab[a] = leaf_tab[b]; leaf_tab[b] = tf;
    endfunction

    // Bump weights from the leaf up to the root, reordering as we go
    function automatic void bump_weights(input logic [7:0] c);
        int cur;
        int steps;
        int pos;
        cur   = find_leaf(c);
        steps = 0;
        while (cur >= 1 && steps < ahtc_pkg::NODES) begin
            wt_tab[cur] = wt_tab[cur] + 1;
            pos = 0;
            for (int i = cur - 1; i > 1; i--)
                if (wt_tab[i] < wt_tab[cur]) pos = i;
            if (pos != 0) begin
                swap_entries(cur, pos);
                cur = pos;
            end
            cur = clip(par_tab[cur]);
            steps++;
        end
    endfunction

    function automatic void split_escape(input logic [7:0] c);
        int e;
        e = esc_idx;
        put_node(e, 0, 1, e + 1, e + 2, par_tab[clip(e)], 0);
        put_node(e + 1, c, 0, 0, 0, e, 1);
        put_node(e + 2, 0, 1, 0, 0, e, 1);
        esc_idx  = (e + 2) & 10'h3FF;
        used_cnt = (used_cnt + 2) & 10'h3FF;
    endfunction

    // Walk leaf to root and queue the code chunks
    function automatic void queue_code(input int leaf, input logic is_new, input logic sat);
        logic [ahtc_pkg::MAX_BITS-1:0] bits;
        int     pos, len, nch, rem, par;
        t_chunk w;
        bits = '0;
        pos  = clip(leaf);
        len  = 0;
        while (pos > 1 && len < ahtc_pkg::MAX_BITS) begin
            par = clip(par_tab[pos]);
            if (pos == rgt_tab[par]) bits[len] = 1'b1;
            pos = par;
            len++;
        end
        nch = (len + 63) / 64;
        if (nch == 0) nch = 1;
        for (int k = 0; k < nch; k++) begin
            rem      = (len < k * 64) ? 0 : len - k * 64;
            w.chunk  = bits[k*64 +: 64];
            w.nbits  = 7'(rem > 64 ? 64 : rem);
            w.is_new = is_new;
            w.sat    = sat;
            w.last   = (k == nch - 1);
            chunk_queue.push_back(w);
        end
    endfunction

    function automatic void code_symbol(input logic [7:0] c, input logic endr);
        logic sat;
        int   leaf;
        if (endr) begin
            queue_code(end_idx, 0, 0);
            return;
        end
        sat  = (wt_tab[1] == ahtc_pkg::WEIGHT_LIMIT);
        leaf = find_leaf(c);
        if (leaf == 0) begin
            queue_code(esc_idx, 1, sat);
            if (esc_idx + 2 >= ahtc_pkg::NODES) return;
            split_escape(c);
        end else begin
            queue_code(leaf, 0, sat);
        end
        if (!sat) bump_weights(c);
    endfunction

    initial begin
        fail_count  = 0;
        pending_cnt = 0;
    end

    // Predict on accepted input words, compare accepted output words
    always @(posedge i_clk) begin
        t_chunk w;
        if (!i_rst_n) begin
            reset_tree();
            chunk_queue.delete();
        end else begin
            if (i_valid && i_ready_in) code_symbol(i_symbol, i_end_request);
            if (i_out_valid && i_out_ready) begin
                if (chunk_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: chunk=%h bits=%0d", i_code_chunk,
                                 i_chunk_bits);
                end else begin
                    w = chunk_queue.pop_front();
                    if (w.chunk !== i_code_chunk || w.nbits !== i_chunk_bits ||
                        w.is_new !== i_is_new || w.sat !== i_weight_saturated ||
                        w.last !== i_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp chunk=%h bits=%0d new=%b sat=%b last=%b",
                                     w.chunk, w.nbits, w.is_new, w.sat, w.last,
                                     " got chunk=%h bits=%0d new=%b sat=%b last=%b",
                                     i_code_chunk, i_chunk_bits, i_is_new,
                                     i_weight_saturated, i_last);
                    end
                end
            end
        end
        pending_cnt = chunk_queue.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_WAIT  = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_symbol;
    logic        i_end_request;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_code_chunk;
    logic [6:0]  o_chunk_bits;
    logic        o_is_new;
    logic        o_weight_saturated;
    logic        o_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_stall_pct;
    logic [7:0] seen_syms[$];

    adaptive_huffman_tree_coder_top u_dut (.*);

    ahtc_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .i_ready_in         (o_ready),
        .i_symbol           (i_symbol),
        .i_end_request      (i_end_request),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_code_chunk       (o_code_chunk),
        .i_chunk_bits       (o_chunk_bits),
        .i_is_new           (o_is_new),
        .i_weight_saturated (o_weight_saturated),
        .i_last             (o_last),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the output side at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Bail out if the run hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Offer one word and hold it until taken
    task automatic send_word(input logic [7:0] sym, input logic endr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_symbol      <= sym;
        i_end_request <= endr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_byte(input logic [7:0] sym);
        send_word(sym, 1'b0);
        seen_syms.push_back(sym);
    endtask

    initial begin
        logic [7:0] s;
        int roll;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_symbol       = '0;
        i_end_request  = 1'b0;
        i_ready        = 1'b0;
        send_idle_pct  = 9;
        recv_stall_pct = 68;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: end leaf before anything, extremes, repeats, end with payload
        send_word(8'h00, 1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_word(8'hA5, 1'b1);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h55);
        send_word(8'hFF, 1'b1);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'h00);

        // Hold off until the block has drained
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        // Random: mostly repeats of known bytes, some new bytes and end requests
        for (int n = 0; n < 300; n++) begin
            if (n == 100) begin
                send_idle_pct  = 68;
                recv_stall_pct = 9;
            end else if (n == 200) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            roll = $urandom_range(99);
            if (roll < 6) begin
                send_word(8'($urandom), 1'b1);
            end else if (roll < 30 || seen_syms.size() == 0) begin
                send_byte(8'($urandom));
            end else begin
                s = seen_syms[$urandom_range(seen_syms.size() - 1)];
                send_byte(s);
            end
        end
        i_valid <= 1'b0;

        // Drain, then give the block time to finish its update
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[files.f]
src/ahtc_pkg.sv
src/ahtc_chunk_out.sv
src/adaptive_huffman_tree_coder_top.sv
src/ahtc_checker.sv
sim/ahtc_checker.sv
sim/tb_top.sv
